FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the button gesture mode controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/bgm_pkg.sv
// Types and constants shared by the button gesture mode controller modules.
package bgm_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REG  = 2'd1,
    MODE_PEND = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_LONG      = 3'd1,
    CFG_GAP       = 3'd2,
    CFG_TIMEOUT   = 3'd3,
    CFG_BLINK     = 3'd4,
    CFG_PATTERN   = 3'd5
  } cfg_idx_t;

  localparam logic [15:0] SAT16         = 16'hFFFF;
  localparam logic [15:0] FLASH_A_END   = 16'd200;
  localparam logic [15:0] FLASH_B_START = 16'd400;
  localparam logic [15:0] FLASH_B_END   = 16'd600;
  localparam logic [1:0]  CLICK_MAX     = 2'd3;
  localparam logic [1:0]  CLICK_DOUBLE  = 2'd2;

  localparam logic [15:0] RST_DEBOUNCE  = 16'd50;
  localparam logic [15:0] RST_LONG      = 16'd1000;
  localparam logic [15:0] RST_GAP       = 16'd400;
  localparam logic [15:0] RST_TIMEOUT   = 16'd2000;
  localparam logic [15:0] RST_BLINK     = 16'd200;
  localparam logic [15:0] RST_PATTERN   = 16'd1300;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] click_gap_ms;
    logic [15:0] confirm_timeout_ms;
    logic [15:0] blink_half_ms;
    logic [15:0] pattern_period_ms;
  } cfg_t;

  typedef struct packed {
    logic registration_done;
    logic cancel_request;
    logic register_request;
    logic button_level;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic        prev_level;
    logic [15:0] press_elapsed;
    logic [15:0] release_elapsed;
    logic [1:0]  click_tally;
    logic [15:0] blink_elapsed;
    logic        blink_phase;
    logic [15:0] pattern_phase;
    logic        led_level;
  } state_t;

  typedef struct packed {
    logic  confirm_waiting;
    logic  reg_aborted;
    logic  reset_timed_out;
    logic  clear_store;
    logic  led_on;
    mode_t mode;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

endpackage

FILE: hw/rtl/button_gesture_mode_controller.sv
// Top level of the button gesture mode controller: channels, state and result registers.
// One input transaction is one millisecond tick and yields exactly one result transaction.
// The block takes a tick in every clock cycle while the output is not stalled; a tick passes
// an input register, then compare and count logic that updates the gesture state and loads
// the result register, which presents the result. A stalled output holds the tick in the
// input register. The state update is the only loop, which sets the rate of one tick per
// clock. Configuration writes are always accepted and take effect on the next tick.
`include "assert_macros.svh"

module button_gesture_mode_controller
  import bgm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [0] button_level, [1] register_request, [2] cancel_request, [3] registration_done
  input  logic [7:0]           in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [1:0] mode, [2] led_on, [3] clear_store, [4] reset_timed_out,
  // [5] reg_aborted, [6] confirm_waiting
  output logic [7:0]           out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t    cfg;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  logic    item_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;

  assign cfg_ready = 1'b1;

  bgm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bgm_step u_step (
    .cfg     (cfg),
    .st_cur  (state_r),
    .item    (item_r),
    .st_next (state_nxt),
    .res     (res_nxt)
  );

  // The held tick moves on whenever the result register is free or being emptied.
  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r.mode            <= MODE_IDLE;
      state_r.prev_level      <= 1'b1;
      state_r.press_elapsed   <= 16'd0;
      state_r.release_elapsed <= 16'd0;
      state_r.click_tally     <= 2'd0;
      state_r.blink_elapsed   <= 16'd0;
      state_r.blink_phase     <= 1'b0;
      state_r.pattern_phase   <= 16'd0;
      state_r.led_level       <= 1'b0;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[3:0]);
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

  `ASSERT_IMPLIES(a_free_input_ready, clk, rst_n, !item_valid_r, in_tready)
  `ASSERT_IMPLIES(a_clear_leaves_idle, clk, rst_n, out_valid_r && res_r.clear_store,
                  res_r.mode == MODE_IDLE)
  `ASSERT_IMPLIES(a_wait_in_pending, clk, rst_n, out_valid_r && res_r.confirm_waiting,
                  res_r.mode == MODE_PEND)
  `ASSERT_NEXT(a_advance_fills_output, clk, rst_n, advance, out_valid_r)

endmodule

FILE: hw/rtl/bgm_cfg_regs.sv
// Configuration register file with write decoder and reset values.
module bgm_cfg_regs
  import bgm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_DEBOUNCE: cfg_nxt.debounce_ms        = wr_data;
        CFG_LONG:     cfg_nxt.long_press_ms      = wr_data;
        CFG_GAP:      cfg_nxt.click_gap_ms       = wr_data;
        CFG_TIMEOUT:  cfg_nxt.confirm_timeout_ms = wr_data;
        CFG_BLINK:    cfg_nxt.blink_half_ms      = wr_data;
        CFG_PATTERN:  cfg_nxt.pattern_period_ms  = wr_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms        <= RST_DEBOUNCE;
      cfg_r.long_press_ms      <= RST_LONG;
      cfg_r.click_gap_ms       <= RST_GAP;
      cfg_r.confirm_timeout_ms <= RST_TIMEOUT;
      cfg_r.blink_half_ms      <= RST_BLINK;
      cfg_r.pattern_period_ms  <= RST_PATTERN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/bgm_step.sv
// Next-state and result logic for one millisecond tick.
module bgm_step
  import bgm_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st_cur,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  // Values carried from the mode/button block into the LED block.
  mode_t       mode_mid;
  logic        led_mid;
  logic [15:0] press_n;
  logic [15:0] release_n;
  logic [1:0]  tally_n;
  logic [15:0] blink_tick;
  logic [15:0] phase_n;
  logic [16:0] phase_sum;
  logic        skip_gap;
  logic        cleared;
  logic        timed_out;
  logic        cancelled;
  logic        waiting;
  logic        rising;
  logic        falling;
  logic        flash_on;

  assign phase_sum  = {1'b0, st_cur.pattern_phase} + 17'd1;
  assign phase_n    = (phase_sum >= {1'b0, cfg.pattern_period_ms}) ? 16'd0 : phase_sum[15:0];
  assign blink_tick = sat_inc(st_cur.blink_elapsed);
  assign rising     = item.button_level & ~st_cur.prev_level;
  assign falling    = ~item.button_level & st_cur.prev_level;
  assign flash_on   = (phase_n < FLASH_A_END) ||
                      ((phase_n > FLASH_B_START) && (phase_n < FLASH_B_END));

  // Mode transitions driven by the requests and the button.
  always_comb begin
    mode_mid  = st_cur.mode;
    led_mid   = st_cur.led_level;
    press_n   = sat_inc(st_cur.press_elapsed);
    release_n = sat_inc(st_cur.release_elapsed);
    tally_n   = st_cur.click_tally;
    skip_gap  = 1'b0;
    cleared   = 1'b0;
    timed_out = 1'b0;
    cancelled = 1'b0;
    waiting   = 1'b0;

    if (item.cancel_request) begin
      mode_mid  = MODE_IDLE;
      led_mid   = 1'b0;
      cancelled = 1'b1;
    end
    if (item.register_request) begin
      mode_mid = MODE_REG;
    end

    if (mode_mid == MODE_PEND && release_n > cfg.confirm_timeout_ms) begin
      mode_mid  = MODE_IDLE;
      tally_n   = 2'd0;
      led_mid   = 1'b0;
      timed_out = 1'b1;
    end
    if (falling) begin
      press_n = 16'd0;
    end
    if (rising) begin
      release_n = 16'd0;
      if (press_n < cfg.debounce_ms) begin
        skip_gap = 1'b1;
      end else if (mode_mid == MODE_REG) begin
        mode_mid  = MODE_IDLE;
        led_mid   = 1'b0;
        cancelled = 1'b1;
        skip_gap  = 1'b1;
      end else if (mode_mid == MODE_PEND) begin
        mode_mid = MODE_IDLE;
        tally_n  = 2'd0;
        led_mid  = 1'b0;
        cleared  = 1'b1;
        skip_gap = 1'b1;
      end else if (press_n >= cfg.long_press_ms) begin
        mode_mid = MODE_REG;
        tally_n  = 2'd0;
      end else if (tally_n < CLICK_MAX) begin
        tally_n = tally_n + 2'd1;
      end
    end
    // A quiet gap closes the click sequence; only a double click counts.
    if (!skip_gap && mode_mid == MODE_IDLE && tally_n != 2'd0 &&
        release_n > cfg.click_gap_ms) begin
      if (tally_n == CLICK_DOUBLE) begin
        mode_mid = MODE_PEND;
        waiting  = 1'b1;
      end
      tally_n = 2'd0;
    end
  end

  // LED drive, blink timer and the final registration-done exit.
  always_comb begin
    st_next                 = st_cur;
    st_next.prev_level      = item.button_level;
    st_next.press_elapsed   = press_n;
    st_next.release_elapsed = release_n;
    st_next.click_tally     = tally_n;
    st_next.pattern_phase   = phase_n;
    st_next.blink_elapsed   = blink_tick;
    st_next.mode            = mode_mid;
    st_next.led_level       = led_mid;

    unique case (mode_mid)
      MODE_REG: begin
        if (blink_tick >= cfg.blink_half_ms) begin
          st_next.blink_elapsed = 16'd0;
          st_next.blink_phase   = ~st_cur.blink_phase;
          st_next.led_level     = ~st_cur.blink_phase;
        end
      end
      MODE_PEND: st_next.led_level = flash_on;
      default:   st_next.led_level = 1'b0;
    endcase

    if (mode_mid == MODE_REG && item.registration_done) begin
      st_next.mode      = MODE_IDLE;
      st_next.led_level = 1'b0;
    end

    res.mode            = st_next.mode;
    res.led_on          = st_next.led_level;
    res.clear_store     = cleared;
    res.reset_timed_out = timed_out;
    res.reg_aborted     = cancelled;
    res.confirm_waiting = waiting;
  end

endmodule

FILE: tb/tb_button_gesture_mode_controller.sv
// Self-checking testbench for the button gesture mode controller, with its own gesture predictor.
module tb_button_gesture_mode_controller;
  import bgm_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef enum {RX_ALWAYS, RX_COIN, RX_THREE_OF_FOUR, RX_MOSTLY} rx_style_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  // [0] button_level, [1] register_request, [2] cancel_request, [3] registration_done
  logic [7:0]           in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  // [1:0] mode, [2] led_on, [3] clear_store, [4] reset_timed_out,
  // [5] reg_aborted, [6] confirm_waiting
  logic [7:0]           out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // Gesture state of the predictor, kept apart from the block.
  cfg_t        settings;
  mode_t       cur_mode;
  logic        last_level;
  logic [15:0] press_ms;
  logic [15:0] release_ms;
  logic [1:0]  clicks;
  logic [15:0] blink_ms;
  logic        blink_toggle;
  logic [15:0] flash_ms;
  logic        led_lit;

  result_t   tick_status_q[$];
  int        mismatch_count = 0;
  int        ticks_checked = 0;
  int        ticks_sent = 0;
  int        burst_left = 0;
  int        quiet_cycles = 0;
  int        rx_cycle = 0;
  int        rx_hold_left = 0;
  rx_style_t rx_style = RX_ALWAYS;

  button_gesture_mode_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("tick %0d: %s is %0d, predicted %0d", ticks_checked, what, got, want);
    end
  endtask

  // Works out the status of one tick and queues it.
  task automatic compute_tick_status(input item_t it);
    result_t     st;
    logic [16:0] next_flash;
    logic [15:0] held;
    logic        settled;
    st = '0;
    press_ms = bump(press_ms);
    release_ms = bump(release_ms);
    blink_ms = bump(blink_ms);
    next_flash = {1'b0, flash_ms} + 17'd1;
    flash_ms = (next_flash >= {1'b0, settings.pattern_period_ms}) ? 16'd0 : next_flash[15:0];

    if (it.cancel_request) begin
      cur_mode = MODE_IDLE;
      led_lit = 1'b0;
      st.reg_aborted = 1'b1;
    end
    if (it.register_request) begin
      cur_mode = MODE_REG;
    end

    if (cur_mode == MODE_PEND && release_ms > settings.confirm_timeout_ms) begin
      cur_mode = MODE_IDLE;
      clicks = 2'd0;
      led_lit = 1'b0;
      st.reset_timed_out = 1'b1;
    end
    if (!it.button_level && last_level) begin
      press_ms = 16'd0;
    end
    // A release ends the button handling early when it is a bounce or closes a mode.
    settled = 1'b0;
    if (it.button_level && !last_level) begin
      held = press_ms;
      release_ms = 16'd0;
      if (held < settings.debounce_ms) begin
        settled = 1'b1;
      end else if (cur_mode == MODE_REG) begin
        cur_mode = MODE_IDLE;
        led_lit = 1'b0;
        st.reg_aborted = 1'b1;
        settled = 1'b1;
      end else if (cur_mode == MODE_PEND) begin
        cur_mode = MODE_IDLE;
        clicks = 2'd0;
        led_lit = 1'b0;
        st.clear_store = 1'b1;
        settled = 1'b1;
      end else if (held >= settings.long_press_ms) begin
        cur_mode = MODE_REG;
        clicks = 2'd0;
      end else if (clicks < CLICK_MAX) begin
        clicks = clicks + 2'd1;
      end
    end
    if (!settled && cur_mode == MODE_IDLE && clicks != 2'd0 &&
        release_ms > settings.click_gap_ms) begin
      if (clicks == CLICK_DOUBLE) begin
        cur_mode = MODE_PEND;
        st.confirm_waiting = 1'b1;
      end
      clicks = 2'd0;
    end
    last_level = it.button_level;

    case (cur_mode)
      MODE_REG: begin
        if (blink_ms >= settings.blink_half_ms) begin
          blink_ms = 16'd0;
          blink_toggle = ~blink_toggle;
          led_lit = blink_toggle;
        end
      end
      MODE_PEND: begin
        led_lit = (flash_ms < FLASH_A_END) ||
                  (flash_ms > FLASH_B_START && flash_ms < FLASH_B_END);
      end
      default: begin
        led_lit = 1'b0;
      end
    endcase

    if (cur_mode == MODE_REG && it.registration_done) begin
      cur_mode = MODE_IDLE;
      led_lit = 1'b0;
    end
    st.mode = cur_mode;
    st.led_on = led_lit;
    tick_status_q = {tick_status_q, st};
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_tick(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9: gap = $urandom_range(10, 30);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, it};
    do @(posedge clk); while (!in_tready);
    compute_tick_status(it);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Holds the button at one level for a number of ticks, with rare request flags.
  task automatic hold_level(input logic lvl, input int n, input int flag_pct);
    item_t it;
    repeat (n) begin
      it = '0;
      it.button_level = lvl;
      it.register_request = ($urandom_range(0, 99) < flag_pct);
      it.cancel_request = ($urandom_range(0, 99) < flag_pct);
      it.registration_done = ($urandom_range(0, 99) < flag_pct);
      send_tick(it);
    end
  endtask

  task automatic send_flags(input logic [3:0] bits);
    send_tick(item_t'(bits));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tick_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_setting(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEBOUNCE: settings.debounce_ms = value;
      CFG_LONG:     settings.long_press_ms = value;
      CFG_GAP:      settings.click_gap_ms = value;
      CFG_TIMEOUT:  settings.confirm_timeout_ms = value;
      CFG_BLINK:    settings.blink_half_ms = value;
      CFG_PATTERN:  settings.pattern_period_ms = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [15:0] lng,
                                input logic [15:0] gap, input logic [15:0] tmo,
                                input logic [15:0] blk, input logic [15:0] pat);
    wait_idle();
    write_setting(CFG_DEBOUNCE, deb);
    write_setting(CFG_LONG, lng);
    write_setting(CFG_GAP, gap);
    write_setting(CFG_TIMEOUT, tmo);
    write_setting(CFG_BLINK, blk);
    write_setting(CFG_PATTERN, pat);
    cfg_valid <= 1'b0;
  endtask

  // One random gesture, sized from the current settings.
  task automatic play_gesture();
    int deb, lng, gap, tmo, valid_len;
    deb = int'(settings.debounce_ms);
    lng = int'(settings.long_press_ms);
    gap = int'(settings.click_gap_ms);
    tmo = int'(settings.confirm_timeout_ms);
    valid_len = ((deb == 0) ? 1 : deb) + $urandom_range(0, (lng > deb + 1) ? lng - deb - 1 : 0);
    case ($urandom_range(0, 9))
      0, 1: begin
        hold_level(1'b0, $urandom_range(1, deb + 2), 2);
        hold_level(1'b1, $urandom_range(1, gap + 3), 2);
      end
      2, 3: begin
        hold_level(1'b0, ((lng == 0) ? 1 : lng) + $urandom_range(0, 3), 2);
        hold_level(1'b1, $urandom_range(1, 8), 2);
      end
      4, 5, 6: begin
        hold_level(1'b0, valid_len, 1);
        hold_level(1'b1, $urandom_range(1, (gap > 0) ? gap : 1), 1);
        hold_level(1'b0, valid_len, 1);
        hold_level(1'b1, gap + 2 + $urandom_range(0, tmo), 1);
        if ($urandom_range(0, 1)) begin
          hold_level(1'b0, valid_len, 1);
          hold_level(1'b1, 2, 1);
        end else begin
          hold_level(1'b1, tmo + 2, 1);
        end
      end
      7: begin
        repeat ($urandom_range(3, 4)) begin
          hold_level(1'b0, valid_len, 1);
          hold_level(1'b1, 1, 1);
        end
        hold_level(1'b1, gap + 2, 1);
      end
      8: begin
        repeat ($urandom_range(1, 6)) begin
          hold_level(1'($urandom_range(0, 1)), $urandom_range(1, 3), 10);
        end
      end
      default: begin
        send_flags(4'($urandom_range(0, 15)));
      end
    endcase
  endtask

  // Reset values: a bounce, then a double click that enters reset pending and is confirmed.
  task automatic test_reset_defaults();
    hold_level(1'b0, 20, 0);
    hold_level(1'b1, 5, 0);
    hold_level(1'b0, 60, 0);
    hold_level(1'b1, 60, 0);
    hold_level(1'b0, 60, 0);
    hold_level(1'b1, 410, 0);
    hold_level(1'b0, 60, 0);
    hold_level(1'b1, 3, 0);
    send_flags(4'b1001);
  endtask

  task automatic test_special_cases();
    apply_settings(16'd2, 16'd4, 16'd1, 16'd2, 16'd0, 16'd0);
    send_flags(4'b0101);
    send_flags(4'b1001);
    send_flags(4'b1111);
    send_flags(4'b1110);
    hold_level(1'b1, 1, 0);
    hold_level(1'b0, 4, 0);
    hold_level(1'b1, 3, 0);
    hold_level(1'b0, 2, 0);
    hold_level(1'b1, 1, 0);
    repeat (2) begin
      hold_level(1'b0, 2, 0);
      hold_level(1'b1, 1, 0);
    end
    hold_level(1'b1, 2, 0);
    hold_level(1'b0, 2, 0);
    hold_level(1'b1, 1, 0);
    repeat (2) begin
      hold_level(1'b0, 2, 0);
      hold_level(1'b1, 1, 0);
    end
    hold_level(1'b1, 5, 0);
    // Four quick clicks; the gap closes during each press, so no click sequence reaches a double.
    repeat (4) begin
      hold_level(1'b0, 2, 0);
      hold_level(1'b1, 1, 0);
    end
    hold_level(1'b1, 2, 0);
  endtask

  // Every time register at its top value, so the press here is too short to count.
  task automatic test_top_settings();
    apply_settings(SAT16, SAT16, SAT16, SAT16, SAT16, SAT16);
    hold_level(1'b0, 70, 0);
    hold_level(1'b1, 3, 0);
    send_flags(4'b0101);
  endtask

  task automatic test_output_backpressure();
    apply_settings(16'd3, 16'd9, 16'd4, 16'd12, 16'd2, 16'd650);
    rx_hold_left = 400;
    repeat (12) play_gesture();
  endtask

  task automatic test_random_gestures();
    int phase_end;
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1);
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        apply_settings(16'($urandom_range(0, 4)),
                       16'($urandom_range(0, 4) + $urandom_range(0, 10)),
                       16'($urandom_range(0, 8)), 16'($urandom_range(0, 20)),
                       16'($urandom_range(0, 6)),
                       16'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 40)
                                                       : $urandom_range(500, 700)));
      end
      phase_end = ticks_sent + 40;
      while (ticks_sent < phase_end) play_gesture();
    end
  endtask

  // Receiver: its own stall pattern, changed now and then, plus a requested hold-off.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 97 == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS:        out_tready <= 1'b1;
          RX_COIN:          out_tready <= 1'($urandom_range(0, 1));
          RX_THREE_OF_FOUR: out_tready <= (rx_cycle % 4 != 0);
          default:          out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_status
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tick_status_q.size() == 0) begin
        report_mismatch("unpredicted result", out_tdata, 0);
      end else begin
        want = tick_status_q.pop_front();
        got = result_t'(out_tdata[6:0]);
        if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
        if (got.led_on !== want.led_on) report_mismatch("led_on", got.led_on, want.led_on);
        if (got.clear_store !== want.clear_store) begin
          report_mismatch("clear_store", got.clear_store, want.clear_store);
        end
        if (got.reset_timed_out !== want.reset_timed_out) begin
          report_mismatch("reset_timed_out", got.reset_timed_out, want.reset_timed_out);
        end
        if (got.reg_aborted !== want.reg_aborted) begin
          report_mismatch("reg_aborted", got.reg_aborted, want.reg_aborted);
        end
        if (got.confirm_waiting !== want.confirm_waiting) begin
          report_mismatch("confirm_waiting", got.confirm_waiting, want.confirm_waiting);
        end
        if (out_tdata[7] !== 1'b0) report_mismatch("padding bit", out_tdata[7], 0);
        ticks_checked++;
      end
    end
  end

  // Ends the run when no transaction of any kind has happened for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("button_gesture_mode_controller: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_data = '0;
    settings.debounce_ms = RST_DEBOUNCE;
    settings.long_press_ms = RST_LONG;
    settings.click_gap_ms = RST_GAP;
    settings.confirm_timeout_ms = RST_TIMEOUT;
    settings.blink_half_ms = RST_BLINK;
    settings.pattern_period_ms = RST_PATTERN;
    cur_mode = MODE_IDLE;
    last_level = 1'b1;
    press_ms = '0;
    release_ms = '0;
    clicks = '0;
    blink_ms = '0;
    blink_toggle = 1'b0;
    flash_ms = '0;
    led_lit = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_special_cases();
    test_top_settings();
    test_output_backpressure();
    test_random_gestures();

    wait_idle();
    repeat (8) @(negedge clk);
    if (tick_status_q.size() != 0) begin
      report_mismatch("ticks left without result", tick_status_q.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("button_gesture_mode_controller: match");
    end else begin
      $display("button_gesture_mode_controller: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bgm_pkg.sv
hw/rtl/bgm_cfg_regs.sv
hw/rtl/bgm_step.sv
hw/rtl/button_gesture_mode_controller.sv
tb/tb_button_gesture_mode_controller.sv
